@@ rtl/core/bpu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpu_pkg: shared types and constants of the BMP pixel unpacker
// Register indexes, reset values, channel codes and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bpu_pkg;

  localparam int MaxDimDefault = 4096;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_PIXEL_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RED_MASK     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GREEN_MASK   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BLUE_MASK    = 3'd5;

  localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
  localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
  localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;

  // channel codes, extraction order
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // run length counter (up to 32) and scaling divider geometry
  localparam int RunW     = 6;
  localparam int DivW     = 40;
  localparam int DivCntW  = 6;
  localparam int DivSteps = DivW;

  typedef struct packed {
    logic       accept;     // input transaction this cycle
    logic       ch_load;    // load mask and masked word of channel ch
    logic       scan_low;   // drop one trailing zero of the mask
    logic       scan_run;   // count one bit of the mask run
    logic       set_zero;   // channel result = 0 (empty mask)
    logic       set_shift;  // channel result = top 8 bits of the run
    logic       div_load;   // start v*255 / (2^run-1)
    logic       div_step;   // one quotient bit
    logic       set_div;    // channel result = quotient
    logic       out_load;   // move finished 32-bit pixel to the output
    logic [1:0] ch;
  } bpu_cmd_t;

  typedef struct packed {
    logic completes;  // next data byte closes a pixel
    logic mode;       // 32-bit masked mode
    logic m_zero;
    logic m_lsb;
    logic run_ge8;
    logic div_done;
    logic out_free;
  } bpu_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/bpu_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpu_if: channel interfaces of the BMP pixel unpacker
// Byte input stream, pixel output stream and configuration write channel.
// ----------------------------------------------------------------------------
interface bpu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface bpu_pixel_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] column;
  logic [11:0] dest_row;
  logic        last_pixel;

  modport source (output valid, output red, output green, output blue, output column,
                  output dest_row, output last_pixel, input ready);
  modport sink (input valid, input red, input green, input blue, input column,
                input dest_row, input last_pixel, output ready);
endinterface

interface bpu_cfg_if import bpu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [31:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bpu_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpu_ctrl: sequencer of the BMP pixel unpacker
// Takes bytes, and for a finished 32-bit pixel walks the three channels
// through mask scan, run count and scaling.
// ----------------------------------------------------------------------------
module bpu_ctrl import bpu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  bpu_sts_t sts,
  output bpu_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_LOW  = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state, state_next;
  logic [1:0] ch, ch_next;
  logic       chan_end;

  always_comb begin
    cmd        = '0;
    cmd.ch     = ch;
    state_next = state;
    ch_next    = ch;
    in_ready   = 1'b0;
    chan_end   = 1'b0;
    unique case (state)
      S_IDLE: begin
        // 24-bit pixel goes straight to the output register
        in_ready   = sts.completes ? (sts.mode | sts.out_free) : 1'b1;
        cmd.accept = in_valid & in_ready;
        if (cmd.accept && sts.completes && sts.mode) begin
          state_next = S_LOAD;
          ch_next    = CH_RED;
        end
      end
      S_LOAD: begin
        cmd.ch_load = 1'b1;
        state_next  = S_LOW;
      end
      S_LOW: begin
        if (sts.m_zero) begin
          cmd.set_zero = 1'b1;
          chan_end     = 1'b1;
        end else if (sts.m_lsb) begin
          state_next = S_RUN;
        end else begin
          cmd.scan_low = 1'b1;
        end
      end
      S_RUN: begin
        if (sts.m_lsb) begin
          cmd.scan_run = 1'b1;
        end else if (sts.run_ge8) begin
          cmd.set_shift = 1'b1;
          chan_end      = 1'b1;
        end else begin
          cmd.div_load = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.set_div = 1'b1;
          chan_end    = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (chan_end) begin
      if (ch == CH_BLUE) begin
        state_next = S_FIN;
      end else begin
        ch_next    = ch + 2'd1;
        state_next = S_LOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= CH_RED;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

`ifndef SYNTHESIS
  a_fin_after_blue: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (ch == CH_BLUE))
    else $error("pixel finished before the blue channel");

  a_start_red: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.completes && sts.mode) |=> (state == S_LOAD && ch == CH_RED))
    else $error("32-bit pixel did not start at the red channel");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.ch_load, cmd.scan_low, cmd.scan_run, cmd.div_load, cmd.div_step,
              cmd.accept}))
    else $error("conflicting datapath commands");
`endif

endmodule
`default_nettype wire

@@ rtl/core/bpu_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpu_datapath: registers and arithmetic of the BMP pixel unpacker
// Config registers, byte assembly, row/column counters, channel extractor
// with a bit-serial scaling divider, and the output register.
// ----------------------------------------------------------------------------
module bpu_datapath import bpu_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  bpu_cmd_t    cmd,
  output bpu_sts_t    sts,
  bpu_cfg_if.sink     cfg,
  bpu_pixel_if.source pixel
);

  localparam int CntW = $clog2(MAX_DIM);
  localparam int LimW = $clog2(MAX_DIM + 1);
  localparam logic [LimW-1:0] LimMax = LimW'(MAX_DIM);
  localparam logic [LimW-1:0] LimOne = LimW'(1);

  // configuration
  logic               pixel_mode;
  logic [12:0]        image_width;
  logic signed [13:0] image_height;
  logic [31:0]        red_mask, green_mask, blue_mask;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode   <= 1'b0;
      image_width  <= 13'd1;
      image_height <= 14'sd1;
      red_mask     <= RED_MASK_RST;
      green_mask   <= GREEN_MASK_RST;
      blue_mask    <= BLUE_MASK_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PIXEL_MODE:   pixel_mode   <= cfg.data[0];
        REG_IMAGE_WIDTH:  image_width  <= cfg.data[12:0];
        REG_IMAGE_HEIGHT: image_height <= signed'(cfg.data[13:0]);
        REG_RED_MASK:     red_mask     <= cfg.data;
        REG_GREEN_MASK:   green_mask   <= cfg.data;
        REG_BLUE_MASK:    blue_mask    <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective dimensions
  logic            top_down;
  logic [13:0]     h_mag;
  logic [LimW-1:0] eff_w, eff_h;

  always_comb begin
    top_down = image_height[13];
    h_mag    = top_down ? (14'd0 - $unsigned(image_height)) : $unsigned(image_height);
    if (image_width == 13'd0)               eff_w = LimOne;
    else if (32'(image_width) > MAX_DIM)    eff_w = LimMax;
    else                                    eff_w = LimW'(image_width);
    if (h_mag == 14'd0)                     eff_h = LimOne;
    else if (32'(h_mag) > MAX_DIM)          eff_h = LimMax;
    else                                    eff_h = LimW'(h_mag);
  end

  // stream position
  logic [1:0]      byte_slot;
  logic [23:0]     word_acc;
  logic [CntW-1:0] column_count, source_row;
  logic [1:0]      pad_left;

  logic            completes, row_end, row_wrap, pix_take, load_24;
  logic [1:0]      pad_new;
  logic [LimW-1:0] col_inc, row_inc, row_ext, dest;
  logic [31:0]     col_ext, dest_ext;

  always_comb begin
    completes = (pad_left == 2'd0) && (byte_slot >= (pixel_mode ? 2'd3 : 2'd2));
    col_inc   = LimW'(column_count) + LimOne;
    row_ext   = LimW'(source_row);
    row_inc   = row_ext + LimOne;
    row_end   = col_inc >= eff_w;
    row_wrap  = row_inc >= eff_h;
    // 3 bytes per pixel: padding equals width mod 4
    pad_new   = pixel_mode ? 2'd0 : eff_w[1:0];
    if (!top_down)            dest = row_ext;
    else if (row_ext < eff_h) dest = eff_h - LimOne - row_ext;
    else                      dest = '0;
    col_ext   = 32'(column_count);
    dest_ext  = 32'(dest);
    pix_take  = cmd.accept && completes;
    load_24   = pix_take && !pixel_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_slot    <= 2'd0;
      word_acc     <= '0;
      column_count <= '0;
      source_row   <= '0;
      pad_left     <= 2'd0;
    end else if (cmd.accept) begin
      if (pad_left != 2'd0) begin
        pad_left <= pad_left - 2'd1;
        if (pad_left == 2'd1) begin
          column_count <= '0;
          source_row   <= row_wrap ? '0 : source_row + CntW'(1);
        end
      end else if (!completes) begin
        case (byte_slot)
          2'd0:    word_acc[7:0]   <= data_byte;
          2'd1:    word_acc[15:8]  <= data_byte;
          2'd2:    word_acc[23:16] <= data_byte;
          default: ;
        endcase
        byte_slot <= byte_slot + 2'd1;
      end else begin
        byte_slot <= 2'd0;
        word_acc  <= '0;
        if (!row_end) begin
          column_count <= column_count + CntW'(1);
        end else if (pad_new != 2'd0) begin
          pad_left <= pad_new;
        end else begin
          column_count <= '0;
          source_row   <= row_wrap ? '0 : source_row + CntW'(1);
        end
      end
    end
  end

  // pixel metadata held while the 32-bit channels are worked out
  logic [31:0] word_reg;
  logic [11:0] meta_col, meta_row;
  logic        meta_last;

  always_ff @(posedge clk) begin
    if (pix_take) begin
      word_reg  <= {data_byte, word_acc};
      meta_col  <= col_ext[11:0];
      meta_row  <= dest_ext[11:0];
      meta_last <= row_end && row_wrap;
    end
  end

  // channel extractor
  logic [31:0]        mask_sel, m_reg, v_reg, shift_val;
  logic [RunW-1:0]    run;
  logic [4:0]         sh_amt;
  logic [7:0]         res_r, res_g, res_b, res_new;
  logic [DivW-1:0]    div_n;
  logic [6:0]         div_rem, div_d;
  logic [7:0]         div_q, div_t;
  logic [DivCntW-1:0] div_cnt;
  logic               div_ge;

  always_comb begin
    case (cmd.ch)
      CH_RED:   mask_sel = red_mask;
      CH_GREEN: mask_sel = green_mask;
      default:  mask_sel = blue_mask;
    endcase
    sh_amt    = 5'(run - RunW'(8));
    shift_val = v_reg >> sh_amt;
    div_d     = 7'((8'd1 << run[2:0]) - 8'd1);
    div_t     = {div_rem, div_n[DivW-1]};
    div_ge    = div_t >= {1'b0, div_d};
    if (cmd.set_shift)    res_new = shift_val[7:0];
    else if (cmd.set_div) res_new = div_q;
    else                  res_new = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.ch_load) begin
      m_reg <= mask_sel;
      v_reg <= word_reg & mask_sel;
      run   <= '0;
    end else if (cmd.scan_low) begin
      m_reg <= m_reg >> 1;
      v_reg <= v_reg >> 1;
    end else if (cmd.scan_run) begin
      m_reg <= m_reg >> 1;
      run   <= run + RunW'(1);
    end
    if (cmd.div_load) begin
      div_n   <= {v_reg, 8'd0} - DivW'(v_reg);   // v * 255
      div_rem <= '0;
      div_q   <= '0;
      div_cnt <= DivCntW'(DivSteps);
    end else if (cmd.div_step) begin
      div_n   <= div_n << 1;
      div_rem <= div_ge ? 7'(div_t - {1'b0, div_d}) : div_t[6:0];
      div_q   <= {div_q[6:0], div_ge};
      div_cnt <= div_cnt - DivCntW'(1);
    end
    if (cmd.set_zero || cmd.set_shift || cmd.set_div) begin
      case (cmd.ch)
        CH_RED:   res_r <= res_new;
        CH_GREEN: res_g <= res_new;
        default:  res_b <= res_new;
      endcase
    end
  end

  // output register
  logic        out_valid;
  logic [7:0]  out_red, out_green, out_blue;
  logic [11:0] out_col, out_row;
  logic        out_last, out_free;

  assign out_free = !out_valid || pixel.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_24 || cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_24) begin
      out_red   <= data_byte;
      out_green <= word_acc[15:8];
      out_blue  <= word_acc[7:0];
      out_col   <= col_ext[11:0];
      out_row   <= dest_ext[11:0];
      out_last  <= row_end && row_wrap;
    end else if (cmd.out_load) begin
      out_red   <= res_r;
      out_green <= res_g;
      out_blue  <= res_b;
      out_col   <= meta_col;
      out_row   <= meta_row;
      out_last  <= meta_last;
    end
  end

  assign pixel.valid      = out_valid;
  assign pixel.red        = out_red;
  assign pixel.green      = out_green;
  assign pixel.blue       = out_blue;
  assign pixel.column     = out_col;
  assign pixel.dest_row   = out_row;
  assign pixel.last_pixel = out_last;

  always_comb begin
    sts.completes = completes;
    sts.mode      = pixel_mode;
    sts.m_zero    = m_reg == 32'd0;
    sts.m_lsb     = m_reg[0];
    sts.run_ge8   = run >= RunW'(8);
    sts.div_done  = div_cnt == '0;
    sts.out_free  = out_free;
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load_24 || cmd.out_load) |-> out_free)
    else $error("output register loaded while a pixel is pending");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (div_rem < div_d))
    else $error("divider remainder out of range");

  a_pad_slot: assert property (@(posedge clk) disable iff (rst)
    (pad_left != 2'd0) |-> (byte_slot == 2'd0))
    else $error("padding pending inside a pixel");
`endif

endmodule
`default_nettype wire

@@ rtl/core/bmp_pixel_unpacker_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_pixel_unpacker_top: BMP pixel array to RGB888 pixel converter
// Top level; joins the byte sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   byte_stream  - raw pixel array bytes in file order, one per transaction.
//   pixel_stream - one transaction per pixel: red/green/blue, column, dest_row,
//                  last_pixel on the final pixel of the image. Row padding bytes
//                  are consumed and produce no transaction.
//   cfg          - register writes (index 0..5: mode, width, height, red, green,
//                  blue mask). Always ready; write only while the block is idle.
// Throughput and sequencing:
//   24-bit mode: one byte per cycle while the output register can take a closing
//   byte; a pixel appears on pixel_stream the cycle after its red byte.
//   32-bit mode: after the fourth byte each channel is extracted in turn on one
//   shared scan unit and a bit-serial divider: the trailing zeros of the mask are
//   dropped, then the ones of the mask run are counted into run (an empty mask
//   gives 0); when run < 8 a 40-step v*255/(2^run-1) division follows, else the
//   top 8 bits of the run are taken. The pixel then moves out once the output
//   register is free. No byte is taken during this sequence.
// Reset (rst, synchronous): registers return to 24-bit mode, 1x1 image, masks
//   00FF0000/0000FF00/000000FF; position returns to column 0, row 0.
// Stall: a finished pixel waits in the output register; bytes that do not close
//   a pixel keep flowing, a closing 24-bit byte waits for the register to free.
// ----------------------------------------------------------------------------
module bmp_pixel_unpacker_top import bpu_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic        clk,
  input  logic        rst,
  bpu_byte_if.sink    byte_stream,
  bpu_pixel_if.source pixel_stream,
  bpu_cfg_if.sink     cfg
);

  // command / status between sequencer and datapath
  bpu_cmd_t cmd;
  bpu_sts_t sts;

  // sequencer owns byte_stream.ready
  bpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_stream.valid),
    .in_ready (byte_stream.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath owns config registers and the output register
  bpu_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .data_byte (byte_stream.data_byte),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg),
    .pixel     (pixel_stream)
  );

endmodule
`default_nettype wire
